// File: src/dcpu_binary_alu_with_ex_defines.svh
// assertion macros shared by the checker file
// no dependencies
`ifndef DCPU_BINARY_ALU_WITH_EX_DEFINES_SVH
`define DCPU_BINARY_ALU_WITH_EX_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DCPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcpu alu check failed");

// next-cycle implication
`define DCPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcpu alu check failed");

`endif

// File: src/dcpu_pkg.sv
// types and constants for the dcpu two-operand alu
// no dependencies
package dcpu_pkg;

  localparam int unsigned WordW = 16;

  typedef enum logic [4:0] {
    OP_SET = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_MLI = 5'd4,
    OP_DIV = 5'd5, OP_DVI = 5'd6, OP_MOD = 5'd7, OP_MDI = 5'd8, OP_AND = 5'd9,
    OP_BOR = 5'd10, OP_XOR = 5'd11, OP_SHR = 5'd12, OP_ASR = 5'd13,
    OP_SHL = 5'd14, OP_IFB = 5'd15, OP_IFC = 5'd16, OP_IFE = 5'd17,
    OP_IFN = 5'd18, OP_IFG = 5'd19, OP_IFA = 5'd20, OP_IFL = 5'd21,
    OP_IFU = 5'd22, OP_ADX = 5'd23, OP_SBX = 5'd24, OP_STI = 5'd25,
    OP_STD = 5'd26
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands, start
    logic div_start; // set up the divider
    logic div_step;  // one quotient bit
    logic finish;    // form the result and update ex
  } dcpu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_div; // operation uses the divider
    logic div_done;  // all quotient bits produced
  } dcpu_sts_t;

endpackage

// File: src/dcpu_binary_alu_with_ex.sv
// top level of the dcpu two-operand alu with overflow register ex
// depends on dcpu_pkg, dcpu_ctrl, dcpu_dpath
//
// One item at a time. An accepted item passes through the divide and finish
// states before the result is valid. Divide-class operations (div, dvi, mod,
// mdi) stay in the divide state while the bit-serial restoring divider forms
// one quotient bit per cycle: 16 bits for dvi/mod/mdi, 32 for div, whose ex
// value is the low half of the 32-bit quotient of x<<16. The result register
// holds the item until taken; the next item is accepted in the cycle after that.
module dcpu_binary_alu_with_ex
  import dcpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[4:0], operand_a[20:5], operand_b[36:21]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_value[15:0], result_write[16],
                                  // ex_value[32:17], skip_next[33], index_step[35:34]
);

  dcpu_cmd_t        cmd;
  dcpu_sts_t        sts;
  logic             busy, out_full;
  logic [WordW-1:0] rv, rex;
  logic             rw, rs;
  logic [1:0]       rst_step;

  assign in_tready  = ~busy;
  assign out_tvalid = out_full;

  dcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid & in_tready),
    .out_fire (out_tvalid & out_tready),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_full (out_full)
  );

  dcpu_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_action (in_tdata[4:0]),
    .in_a      (in_tdata[20:5]),
    .in_b      (in_tdata[36:21]),
    .sts       (sts),
    .res_value (rv),
    .res_write (rw),
    .res_ex    (rex),
    .res_skip  (rs),
    .res_step  (rst_step)
  );

  assign out_tdata = {4'b0000, rst_step, rs, rex, rw, rv};

endmodule

// File: src/dcpu_ctrl.sv
// controller state machine for the dcpu alu
// depends on dcpu_pkg
module dcpu_ctrl
  import dcpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_fire,
  input  dcpu_sts_t sts,
  output dcpu_cmd_t cmd,
  output logic      busy,
  output logic      out_full
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_full = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!sts.needs_div || sts.div_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_full = 1'b1;
        if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.div_start = cmd.load;
  end

endmodule

// File: src/dcpu_dpath.sv
// datapath for the dcpu alu: operand registers, restoring divider, result logic, ex
// depends on dcpu_pkg
module dcpu_dpath
  import dcpu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dcpu_cmd_t        cmd,
  input  logic [4:0]       in_action,
  input  logic [WordW-1:0] in_a,
  input  logic [WordW-1:0] in_b,
  output dcpu_sts_t        sts,
  output logic [WordW-1:0] res_value,
  output logic             res_write,
  output logic [WordW-1:0] res_ex,
  output logic             res_skip,
  output logic [1:0]       res_step
);

  logic [4:0]       op_r;
  logic [WordW-1:0] x_r, y_r, ex_r;
  // divider: 32-bit dividend x<<16 gives quotient 32 bits; low 16 of remainder path
  logic [2*WordW-1:0] dvd_r;   // dividend shifting out
  logic [2*WordW-1:0] quo_r;
  logic [WordW:0]     rem_r;
  logic [WordW-1:0]   dvs_r;
  logic [5:0]         cnt_r;
  logic [5:0]         nbits;
  logic               div_signed;
  logic [WordW-1:0]   ax, ay;
  logic [WordW:0]     rem_sh;
  logic [WordW:0]     rem_sub;

  assign div_signed = (in_action == OP_DVI) || (in_action == OP_MDI);
  assign ax = (div_signed && in_b[WordW-1]) ? WordW'(-in_b) : in_b;
  assign ay = (div_signed && in_a[WordW-1]) ? WordW'(-in_a) : in_a;
  assign nbits = (in_action == OP_DIV) ? 6'd32 : 6'd16;

  assign sts.needs_div = (op_r == OP_DIV) || (op_r == OP_DVI) ||
                         (op_r == OP_MOD) || (op_r == OP_MDI);
  assign sts.div_done  = (cnt_r == 6'd0);

  assign rem_sh  = {rem_r[WordW-1:0], dvd_r[2*WordW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // operand capture and divider iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_action;
      x_r  <= in_b;
      y_r  <= in_a;
    end
    if (cmd.div_start) begin
      dvs_r <= ay;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= nbits;
      dvd_r <= (in_action == OP_DIV) ? {in_b, {WordW{1'b0}}} : {ax, {WordW{1'b0}}};
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[2*WordW-2:0], 1'b0};
      cnt_r <= cnt_r - 6'd1;
      if (!rem_sub[WordW]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[2*WordW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[2*WordW-2:0], 1'b0};
      end
    end
  end

  // result forming
  logic [WordW-1:0]   val;
  logic [WordW-1:0]   ex_nxt;
  logic               wr, tst, is_test;
  logic [1:0]         step;
  logic [WordW:0]     sum;
  logic [2*WordW-1:0] prod, xs32, sh32;
  logic [WordW+1:0]   zsum;
  logic               sgn_neg;
  logic [WordW-1:0]   qu, rm;
  logic               y_big;

  assign prod = x_r * y_r;
  assign xs32 = {{WordW{x_r[WordW-1]}}, x_r};
  assign sgn_neg = x_r[WordW-1] ^ y_r[WordW-1];
  assign qu = quo_r[WordW-1:0];
  assign rm = rem_r[WordW-1:0];
  assign y_big = |y_r[WordW-1:5];

  always_comb begin
    val = '0;
    ex_nxt = ex_r;
    wr = 1'b1;
    tst = 1'b1;
    is_test = 1'b0;
    step = 2'd0;
    sum = '0;
    sh32 = '0;
    zsum = '0;
    case (op_r)
      OP_SET: val = y_r;
      OP_STI: begin val = y_r; step = 2'd1; end
      OP_STD: begin val = y_r; step = 2'd3; end
      OP_ADD: begin
        sum = {1'b0, x_r} + {1'b0, y_r};
        val = sum[WordW-1:0];
        ex_nxt = sum[WordW] ? 16'h0001 : 16'h0000;
      end
      OP_SUB: begin
        sum = {1'b0, x_r} - {1'b0, y_r};
        val = sum[WordW-1:0];
        ex_nxt = sum[WordW] ? 16'hffff : 16'h0000;
      end
      OP_MUL: begin val = prod[WordW-1:0]; ex_nxt = prod[2*WordW-1:WordW]; end
      OP_MLI: val = prod[WordW-1:0];
      OP_DIV: begin
        if (y_r == '0) begin
          val = '0; ex_nxt = '0;
        end else begin
          val = quo_r[2*WordW-1:WordW]; ex_nxt = quo_r[WordW-1:0];
        end
      end
      OP_DVI: val = (y_r == '0) ? '0 : (sgn_neg ? WordW'(-qu) : qu);
      OP_MOD: val = (y_r == '0) ? '0 : rm;
      OP_MDI: val = (y_r == '0) ? '0 : (x_r[WordW-1] ? WordW'(-rm) : rm);
      OP_AND: val = x_r & y_r;
      OP_BOR: val = x_r | y_r;
      OP_XOR: val = x_r ^ y_r;
      OP_SHR: begin
        if (y_big) begin
          val = '0; ex_nxt = '0;
        end else begin
          sh32 = {x_r, {WordW{1'b0}}} >> y_r[4:0];
          val = sh32[2*WordW-1:WordW]; ex_nxt = sh32[WordW-1:0];
        end
      end
      OP_ASR: begin
        // b from sign-extended x, ex from x<<16 arithmetic
        if (y_big) begin
          val = {WordW{x_r[WordW-1]}}; ex_nxt = {WordW{x_r[WordW-1]}};
        end else begin
          sh32 = $signed(xs32) >>> y_r[4:0];
          val = sh32[WordW-1:0];
          sh32 = $signed({x_r, {WordW{1'b0}}}) >>> y_r[4:0];
          ex_nxt = sh32[WordW-1:0];
        end
      end
      OP_SHL: val = (|y_r[WordW-1:4]) ? '0 : (x_r << y_r[3:0]);
      OP_IFB: begin is_test = 1'b1; tst = |(x_r & y_r); end
      OP_IFC: begin is_test = 1'b1; tst = ~|(x_r & y_r); end
      OP_IFE: begin is_test = 1'b1; tst = (x_r == y_r); end
      OP_IFN: begin is_test = 1'b1; tst = (x_r != y_r); end
      OP_IFG: begin is_test = 1'b1; tst = (x_r > y_r); end
      OP_IFA: begin is_test = 1'b1; tst = ($signed(x_r) > $signed(y_r)); end
      OP_IFL: begin is_test = 1'b1; tst = (x_r < y_r); end
      OP_IFU: begin is_test = 1'b1; tst = ($signed(x_r) < $signed(y_r)); end
      OP_ADX: begin
        zsum = {2'b00, x_r} + {2'b00, y_r} + {2'b00, ex_r};
        val = zsum[WordW-1:0];
        ex_nxt = (|zsum[WordW+1:WordW]) ? 16'h0001 : 16'h0000;
      end
      OP_SBX: begin
        // x - y + ex: above 0xffff when negative (wraps) or carries
        zsum = {2'b00, x_r} - {2'b00, y_r} + {2'b00, ex_r};
        val = zsum[WordW-1:0];
        ex_nxt = (|zsum[WordW+1:WordW]) ? 16'h0001 : 16'h0000;
      end
      default: wr = 1'b0;
    endcase
    if (is_test) wr = 1'b0;
  end

  // ex register and output holding registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r <= '0;
    end else if (cmd.finish) begin
      ex_r <= ex_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_value <= wr ? val : '0;
      res_write <= wr;
      res_ex    <= ex_nxt;
      res_skip  <= is_test & ~tst;
      res_step  <= step;
    end
  end

endmodule

// File: src/dcpu_checker.sv
// port-level checker for the dcpu alu, bound to the top level
// depends on dcpu_binary_alu_with_ex_defines.svh
`include "dcpu_binary_alu_with_ex_defines.svh"
module dcpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // one item in flight: no acceptance while a result waits
  `DCPU_ASSERT_IMP(no_accept_with_result, out_tvalid, !in_tready)
  // a stalled result holds
  `DCPU_ASSERT_NXT(out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // an accepted item makes the block busy
  `DCPU_ASSERT_NXT(busy_after_accept, in_tvalid && in_tready, !in_tready)
  // skip and write never together, unused pad bits zero
  `DCPU_ASSERT_IMP(skip_no_write, out_tvalid,
    !(out_tdata[33] && out_tdata[16]) && out_tdata[39:36] == 4'b0000)

endmodule

bind dcpu_binary_alu_with_ex dcpu_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
